### rtl/sve_pkg.sv
`default_nettype none

package sve_pkg;

	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned HEAD_BITS = 6;
	localparam int unsigned GRP_BITS  = 7;
	localparam int unsigned MAX_BYTES = 10;
	localparam int unsigned NIB_BYTES = 5;
	localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

	localparam logic MODE_32 = 1'b0;
	localparam logic MODE_64 = 1'b1;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      mode;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [VALUE_W-1:0] bits;
		cnt_t               cnt;
		logic               neg;
		logic               nib;
	} sve_load_t;

endpackage

`default_nettype wire

### rtl/sve_len.sv
`default_nettype none

module sve_len (
	input  wire logic [sve_pkg::VALUE_W-1:0] bits,
	output sve_pkg::cnt_t                    cnt
);
	import sve_pkg::*;

	logic [VALUE_W-1:0] mag;

	assign mag = bits[VALUE_W-1] ? (~bits + VALUE_W'(1)) : bits;

	always_comb begin
		cnt = CNT_W'(1);
		for (int i = 0; i < MAX_BYTES - 1; i++) begin
			if ((mag >> (HEAD_BITS + GRP_BITS * i)) != '0) begin
				cnt = cnt + CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

### rtl/sve_ser.sv
`default_nettype none

module sve_ser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load_valid,
	input  wire sve_pkg::sve_load_t load,
	output logic                   load_ready,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output sve_pkg::res_t          res
);
	import sve_pkg::*;

	logic               busy_q;
	logic               first_q;
	logic               neg_q;
	logic               nib_q;
	cnt_t               cnt_q;
	logic [VALUE_W-1:0] sh_q;
	logic               res_valid_q;
	res_t               res_q;

	logic       out_free;
	logic       emit;
	logic       last_b;
	logic [7:0] byte_d;

	assign out_free   = !res_valid_q || res_ready;
	assign emit       = busy_q && out_free;
	assign last_b     = (cnt_q == CNT_W'(1));
	assign load_ready = !busy_q || (emit && last_b);

	always_comb begin
		if (first_q) begin
			byte_d = {!last_b, neg_q, sh_q[HEAD_BITS-1:0]};
		end else if (last_b && nib_q) begin
			byte_d = {4'b0000, sh_q[3:0]};
		end else begin
			byte_d = {!last_b, sh_q[GRP_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load_valid && load_ready) begin
			busy_q  <= 1'b1;
			first_q <= 1'b1;
			cnt_q   <= load.cnt;
		end else if (emit) begin
			busy_q  <= !last_b;
			first_q <= 1'b0;
			cnt_q   <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			sh_q  <= load.bits;
			neg_q <= load.neg;
			nib_q <= load.nib;
		end else if (emit) begin
			sh_q <= first_q ? (sh_q >> HEAD_BITS) : (sh_q >> GRP_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.out_byte <= byte_d;
			res_q.last     <= last_b;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### rtl/signed_varint_encoder.sv
// A request is held in the input stage register, then loaded into the serializer.
// Throughput: one byte per cycle while the output is not stalled, set by the single
// byte-wide output register; a request gives 1 to 10 bytes. A new request is taken while
// the last byte of the previous one leaves, so encodings follow one another with no gap.
// Reset: arst_n clears all valid and control state at once; no clearing pass.
`default_nettype none

module signed_varint_encoder (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire sve_pkg::req_t req,
	output logic               res_valid,
	input  wire logic          res_ready,
	output sve_pkg::res_t      res
);
	import sve_pkg::*;

	logic               valid_s1;
	logic [VALUE_W-1:0] bits_s1;
	logic               wide_s1;
	logic [VALUE_W-1:0] bits_d;
	cnt_t               cnt;
	sve_load_t          load;
	logic               load_ready;

	assign bits_d = (req.mode == MODE_64) ? VALUE_W'(req.value)
		: {{(VALUE_W-32){req.value[31]}}, req.value[31:0]};

	assign req_ready = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			bits_s1 <= bits_d;
			wide_s1 <= req.mode;
		end
	end

	sve_len u_len (
		.bits (bits_s1),
		.cnt  (cnt)
	);

	always_comb begin
		load.bits = bits_s1;
		load.cnt  = cnt;
		load.neg  = bits_s1[VALUE_W-1];
		load.nib  = (wide_s1 == MODE_32) && (cnt == CNT_W'(NIB_BYTES));
	end

	sve_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load       (load),
		.load_ready (load_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

`default_nettype wire

### rtl/sve_checker.sv
`default_nettype none

module sve_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire sve_pkg::req_t req,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire sve_pkg::res_t res
);
	import sve_pkg::*;

	cnt_t run_q;
	logic res_take;

	assign res_take = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (res_take) begin
			run_q <= res.last ? '0 : run_q + CNT_W'(1);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result dropped or changed while stalled");

	a_cont_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.out_byte[7] == !res.last))
		else $error("continuation flag disagrees with last");

	a_max_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> (run_q <= CNT_W'(MAX_BYTES - 1)))
		else $error("encoding longer than ten bytes");

	a_tenth: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && (run_q == CNT_W'(MAX_BYTES - 1))
		|-> res.last && (res.out_byte[7:2] == '0))
		else $error("tenth byte malformed");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request dropped or changed while stalled");

endmodule

bind signed_varint_encoder sve_checker u_sve_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

`default_nettype wire
